// ===== src/tlvrx_pkg.sv =====
`timescale 1ns / 1ps

package tlvrx_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int BYTE_W                = 8;
    localparam int CRC_W                 = 16;
    localparam int COUNT_OUT_W           = 32;
    localparam int STATUS_W              = 2;
    localparam int CFG_INDEX_W           = 1;

    // Stream payload widths: tdata carries the byte-sized fields and the
    // three counters, tuser carries the status and the payload flag.
    localparam int TDATA_W = 4 * BYTE_W + 3 * COUNT_OUT_W;
    localparam int TUSER_W = STATUS_W + 1;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h5A;

    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRCERR     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    // Control handed from the stream front end to the parser each cycle.
    typedef struct packed {
        logic              advance;  // result register may load
        logic              fire;     // an item is processed this cycle
        logic [BYTE_W-1:0] data;
    } step_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   payload_index;
    } result_t;

    // CRC-16/CCITT-FALSE update over one byte, MSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, {(CRC_W - BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/tlvrx_parser.sv =====
`timescale 1ns / 1ps

// Frame parser: phase machine, running CRC, held header fields, counters and
// the result register. State moves only when an item is processed, so the
// held fields and counters always match the result that is on display.
module tlvrx_parser #(
    parameter int COUNTER_WIDTH = tlvrx_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tlvrx_pkg::BYTE_W-1:0]   sync_first,
    input  logic [tlvrx_pkg::BYTE_W-1:0]   sync_second,
    input  tlvrx_pkg::step_t               step,
    output tlvrx_pkg::result_t             result,
    output logic [tlvrx_pkg::BYTE_W-1:0]   frame_tag,
    output logic [tlvrx_pkg::BYTE_W-1:0]   frame_length,
    output logic [COUNTER_WIDTH-1:0]       good_count,
    output logic [COUNTER_WIDTH-1:0]       error_count,
    output logic [COUNTER_WIDTH-1:0]       drop_count
);
    import tlvrx_pkg::*;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_TAG   = 3'd2,
        PH_LEN   = 3'd3,
        PH_VALUE = 3'd4,
        PH_CRCHI = 3'd5,
        PH_CRCLO = 3'd6
    } phase_t;

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_TWO = COUNTER_WIDTH'(2);

    phase_t                   phase_reg, phase_next;
    logic [BYTE_W-1:0]        tag_reg, tag_next;
    logic [BYTE_W-1:0]        length_reg, length_next;
    logic [BYTE_W-1:0]        position_reg, position_next;
    logic [CRC_W-1:0]         crc_reg, crc_next;
    logic [BYTE_W-1:0]        crc_high_reg, crc_high_next;
    logic [COUNTER_WIDTH-1:0] good_reg, good_next;
    logic [COUNTER_WIDTH-1:0] error_reg, error_next;
    logic [COUNTER_WIDTH-1:0] drop_reg, drop_next;
    result_t                  result_reg, result_next;

    logic [CRC_W-1:0]  crc_step;
    logic [BYTE_W-1:0] position_inc;

    assign crc_step     = crc16_byte(crc_reg, step.data);
    assign position_inc = position_reg + BYTE_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        length_next   = length_reg;
        position_next = position_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        good_next     = good_reg;
        error_next    = error_reg;
        drop_next     = drop_reg;

        result_next               = '0;
        result_next.valid         = step.fire;
        result_next.status        = ST_INCOMPLETE;

        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (step.data == sync_first)
                    phase_next = PH_SYNC2;
                else
                    drop_next = drop_reg + CNT_ONE;
            end
            PH_SYNC2:
            begin
                // The second sync byte is checked first, so equal sync
                // registers still start a frame.
                if (step.data == sync_second)
                begin
                    crc_next   = CRC_INIT;
                    phase_next = PH_TAG;
                end
                else if (step.data == sync_first)
                    drop_next = drop_reg + CNT_ONE;
                else
                begin
                    drop_next  = drop_reg + CNT_TWO;
                    phase_next = PH_SYNC1;
                end
            end
            PH_TAG:
            begin
                tag_next   = step.data;
                crc_next   = crc_step;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                length_next   = step.data;
                position_next = '0;
                crc_next      = crc_step;
                phase_next    = (step.data == '0) ? PH_CRCHI : PH_VALUE;
            end
            PH_VALUE:
            begin
                result_next.payload_valid = 1'b1;
                result_next.payload_byte  = step.data;
                result_next.payload_index = position_reg;
                crc_next                  = crc_step;
                position_next             = position_inc;
                if (position_inc >= length_reg)
                    phase_next = PH_CRCHI;
            end
            PH_CRCHI:
            begin
                crc_high_next = step.data;
                phase_next    = PH_CRCLO;
            end
            PH_CRCLO:
            begin
                phase_next = PH_SYNC1;
                if ({crc_high_reg, step.data} != crc_reg)
                begin
                    error_next         = error_reg + CNT_ONE;
                    result_next.status = ST_CRCERR;
                end
                else
                begin
                    good_next          = good_reg + CNT_ONE;
                    result_next.status = ST_GOOD;
                end
            end
            default:
            begin
                // Unreachable phase code: drop everything back to reset.
                phase_next    = PH_SYNC1;
                tag_next      = '0;
                length_next   = '0;
                position_next = '0;
                crc_next      = CRC_INIT;
                crc_high_next = '0;
                good_next     = '0;
                error_next    = '0;
                drop_next     = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC1;
            tag_reg      <= '0;
            length_reg   <= '0;
            position_reg <= '0;
            crc_reg      <= CRC_INIT;
            crc_high_reg <= '0;
            good_reg     <= '0;
            error_reg    <= '0;
            drop_reg     <= '0;
            result_reg   <= '0;
        end
        else
        begin
            if (step.fire)
            begin
                phase_reg    <= phase_next;
                tag_reg      <= tag_next;
                length_reg   <= length_next;
                position_reg <= position_next;
                crc_reg      <= crc_next;
                crc_high_reg <= crc_high_next;
                good_reg     <= good_next;
                error_reg    <= error_next;
                drop_reg     <= drop_next;
            end
            if (step.advance)
                result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign frame_tag    = tag_reg;
    assign frame_length = length_reg;
    assign good_count   = good_reg;
    assign error_count  = error_reg;
    assign drop_count   = drop_reg;

    // A value byte never closes a frame.
    a_payload_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
        (result_reg.valid && result_reg.payload_valid) |-> (result_reg.status == ST_INCOMPLETE))
        else $error("payload item carries a final frame status");

    // Hunting for the first sync byte leads only to the second sync phase.
    a_hunt_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && phase_reg == PH_SYNC1) |=> (phase_reg == PH_SYNC1 || phase_reg == PH_SYNC2))
        else $error("first sync hunt left to an unexpected phase");

    // Closing a frame bumps exactly one of the good and error counters.
    a_frame_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && phase_reg == PH_CRCLO) |=>
            ((good_reg != $past(good_reg)) != (error_reg != $past(error_reg))))
        else $error("frame end did not update exactly one counter");

    // A final status is produced only by the CRC low byte.
    a_status_source: assert property (@(posedge clk) disable iff (!rst_n)
        (step.advance && step.fire && phase_reg != PH_CRCLO) |=>
            (result_reg.status == ST_INCOMPLETE))
        else $error("final status reported outside the CRC check");

endmodule

// ===== src/tlv_stream_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// TLV stream frame receiver. Each item on the slave stream is one received
// byte; each byte yields exactly one item on the master stream, in order.
// The receiver hunts for the two-byte sync pair (registers 0 and 1, reset
// 0xA5 and 0x5A), then reads a tag, a length, 0 to 255 value bytes and a
// big-endian CRC-16/CCITT-FALSE over tag, length and value. Value bytes are
// passed out as they arrive with their index and payload_valid set; a
// consumer that buffers them must discard the frame when the closing item
// reports a CRC error. Every output item also shows the held tag and
// length and the good-frame, CRC-error and dropped-byte counts, which wrap
// at COUNTER_WIDTH bits and appear as their low 32 bits. The block takes one
// item per clock cycle while the master stream does not stall. A byte waits
// in the input register while the single-byte CRC step and phase logic work
// out its result, which loads into the result register when that register
// may advance; the master stream is driven from the result register. The
// single-byte CRC update sets the rate. Sync registers must be written by the
// user only while the stream is idle; the block itself does not enforce this.
module tlv_stream_frame_receiver_top #(
    parameter int COUNTER_WIDTH = tlvrx_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tlvrx_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_tag,
    // [31:24] frame_length, [63:32] good_frames, [95:64] crc_failures,
    // [127:96] dropped_bytes
    output logic [tlvrx_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic [tlvrx_pkg::TUSER_W-1:0]      m_axis_tuser,   // [1:0] status, [2] payload_valid
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlvrx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlvrx_pkg::BYTE_W-1:0]       cfg_data
);
    import tlvrx_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;

    logic    advance;
    logic    in_fire;
    step_t   step;
    result_t result;

    logic [BYTE_W-1:0]        frame_tag;
    logic [BYTE_W-1:0]        frame_length;
    logic [COUNTER_WIDTH-1:0] good_count;
    logic [COUNTER_WIDTH-1:0] error_count;
    logic [COUNTER_WIDTH-1:0] drop_count;

    // Counters are widened to 64 bits first so any COUNTER_WIDTH in range
    // maps onto the 32-bit output fields by a plain part-select.
    logic [63:0] good_wide;
    logic [63:0] error_wide;
    logic [63:0] drop_wide;

    // The result register loads whenever it is empty or being drained, so
    // the input register can hand over a byte in the same cycle.
    assign advance       = !result.valid || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            in_byte_reg <= s_axis_tdata;
    end

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    assign step.advance = advance;
    assign step.fire    = in_valid_reg && advance;
    assign step.data    = in_byte_reg;

    tlvrx_parser #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .sync_first   (sync_first_reg),
        .sync_second  (sync_second_reg),
        .step         (step),
        .result       (result),
        .frame_tag    (frame_tag),
        .frame_length (frame_length),
        .good_count   (good_count),
        .error_count  (error_count),
        .drop_count   (drop_count)
    );

    assign good_wide  = 64'(good_count);
    assign error_wide = 64'(error_count);
    assign drop_wide  = 64'(drop_count);

    assign m_axis_tvalid = result.valid;
    assign m_axis_tuser  = {result.payload_valid, result.status};
    assign m_axis_tdata  = {drop_wide[COUNT_OUT_W-1:0],
                            error_wide[COUNT_OUT_W-1:0],
                            good_wide[COUNT_OUT_W-1:0],
                            frame_length,
                            frame_tag,
                            result.payload_index,
                            result.payload_byte};

endmodule
